[rtl/core/lz_window_byte_decompressor_unit_macros.svh]
// Assertion macros shared by the checker.
`ifndef LZ_WINDOW_BYTE_DECOMPRESSOR_UNIT_MACROS_SVH
`define LZ_WINDOW_BYTE_DECOMPRESSOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define LZWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LZWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lzwd_pkg.sv]
package lzwd_pkg;
  localparam int WindowSize = 4096;
  localparam int WinAw = 12;
  localparam int HeaderLen = 16;
  localparam int MaxResults = 36;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;
  localparam logic [1:0] ST_BAD_REF = 2'd3;

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_GROUP = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_LENGTH = 2'd3;

  localparam logic [8:0] LongLenBias = 9'd18;
  localparam logic [8:0] ShortLenBias = 9'd2;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0: m = 8'h59;
      2'd1: m = 8'h61;
      2'd2: m = 8'h7A;
      default: m = 8'h30;
    endcase
    return m;
  endfunction
endpackage

[rtl/core/lzwd_ram.sv]
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[rtl/core/lz_window_byte_decompressor_unit.sv]
// Yaz0 stream decoder. One compressed byte is taken per item; a header, flag or
// literal byte passes the process and end states before the next accept, and a
// back-reference loops the read and write states per copied byte before the end
// state, as every copied byte is read from the 4096-byte history memory and
// written back before the next read. Decoded bytes leave packed up to OUT_LANES
// per item, lowest lane first; the final item carries done and the status.
// Input is held off while an item is being processed, and an item with a result
// stays in processing until the output register is free to take it.
module lz_window_byte_decompressor_unit #(
  parameter int OUT_LANES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data,
  output logic [3:0]  out_count,
  output logic        out_done,
  output logic [1:0]  out_status
);
  import lzwd_pkg::*;

  localparam logic [3:0] Lanes = 4'(OUT_LANES);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROC = 3'd1;
  localparam logic [2:0] S_COPY_RD = 3'd2;
  localparam logic [2:0] S_COPY_WR = 3'd3;
  localparam logic [2:0] S_END = 3'd4;

  logic [2:0]  state;
  logic [31:0] capacity;
  logic [7:0]  ib;
  logic        il;
  logic [4:0]  hidx;
  logic [31:0] exp_size;
  logic [7:0]  flag_bits;
  logic [3:0]  flag_left;
  logic [1:0]  phase;
  logic [7:0]  first;
  logic [12:0] distance;
  logic [31:0] emitted;
  logic        halted;
  logic [8:0]  len_left;
  logic        fin;
  logic        body;
  logic [1:0]  status;
  logic [63:0] lane;
  logic [3:0]  lane_cnt;
  logic [5:0]  res_n;

  logic        out_free;
  logic        wr_en;
  logic [7:0]  wr_data;
  logic        rd_en;
  logic [7:0]  rd_data;
  logic [WinAw-1:0] rd_addr;
  logic [3:0]  flag_dec;
  logic [12:0] dist_new;
  logic [31:0] exp_new;
  logic        cap_hit;
  logic        end_fin;
  logic        can_put;
  logic        put_now;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign flag_dec = (flag_left != 4'd0) ? flag_left - 4'd1 : 4'd0;
  assign dist_new = {1'b0, first[3:0], ib} + 13'd1;
  assign exp_new = {exp_size[23:0], ib};
  assign cap_hit = (emitted >= capacity);
  assign end_fin = fin || (body && ((status != ST_OK) || il || cap_hit));
  assign can_put = out_free || (res_n >= 6'(MaxResults));
  assign put_now = (res_n < 6'(MaxResults)) && can_put &&
                   (((state == S_COPY_WR) && (lane_cnt == Lanes)) ||
                    ((state == S_END) && (end_fin || (lane_cnt != 4'd0))));
  assign rd_addr = emitted[WinAw-1:0] - distance[WinAw-1:0];
  assign rd_en = (state == S_COPY_RD);
  assign wr_en = ((state == S_PROC) && (hidx == 5'(HeaderLen)) && !cap_hit &&
                  (phase == PH_GROUP) && flag_bits[7]) ||
                 ((state == S_COPY_WR) && ((lane_cnt != Lanes) || can_put));
  assign wr_data = (state == S_PROC) ? ib : rd_data;

  lzwd_ram #(.WIDTH(8), .DEPTH(WindowSize)) u_history (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(emitted[WinAw-1:0]),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity <= 32'hFFFF_FFFF;
      hidx <= '0;
      exp_size <= '0;
      flag_bits <= '0;
      flag_left <= '0;
      phase <= PH_FLAG;
      first <= '0;
      distance <= '0;
      emitted <= '0;
      halted <= 1'b0;
      out_valid <= 1'b0;
      fin <= 1'b0;
      body <= 1'b0;
      status <= ST_OK;
      lane_cnt <= '0;
      res_n <= '0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (put_now) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !halted) begin
            ib <= in_byte;
            il <= in_last;
            lane <= '0;
            lane_cnt <= '0;
            res_n <= '0;
            fin <= 1'b0;
            body <= 1'b0;
            status <= ST_OK;
            state <= S_PROC;
          end
        end
        S_PROC: begin
          state <= S_END;
          if (hidx < 5'(HeaderLen)) begin
            hidx <= hidx + 5'd1;
            if (hidx < 5'd4 && ib != magic_byte(hidx[1:0])) begin
              fin <= 1'b1;
              status <= ST_BAD_HEADER;
            end else if (hidx == 5'd7 && exp_new > capacity) begin
              fin <= 1'b1;
              status <= ST_CAPACITY;
            end else if (il) begin
              fin <= 1'b1;
              status <= (hidx < 5'd7) ? ST_BAD_HEADER : ST_OK;
            end else if (hidx == 5'(HeaderLen - 1) && cap_hit) begin
              fin <= 1'b1;
            end
            if (hidx >= 5'd4 && hidx < 5'd8) begin
              exp_size <= exp_new;
            end
          end else if (cap_hit) begin
            fin <= 1'b1;
          end else begin
            body <= 1'b1;
            case (phase)
              PH_FLAG: begin
                flag_bits <= ib;
                flag_left <= 4'd8;
                phase <= PH_GROUP;
              end
              PH_GROUP: begin
                flag_bits <= {flag_bits[6:0], 1'b0};
                flag_left <= flag_dec;
                if (flag_bits[7]) begin
                  lane <= {56'd0, ib};
                  lane_cnt <= 4'd1;
                  emitted <= emitted + 32'd1;
                  phase <= (flag_dec != 4'd0) ? PH_GROUP : PH_FLAG;
                end else begin
                  first <= ib;
                  phase <= PH_SECOND;
                end
              end
              PH_SECOND: begin
                distance <= dist_new;
                if (first[7:4] != 4'd0) begin
                  phase <= (flag_left != 4'd0) ? PH_GROUP : PH_FLAG;
                  len_left <= {5'd0, first[7:4]} + ShortLenBias;
                  if ({19'd0, dist_new} > emitted) begin
                    status <= ST_BAD_REF;
                  end else begin
                    state <= S_COPY_RD;
                  end
                end else begin
                  phase <= PH_LENGTH;
                end
              end
              default: begin
                phase <= (flag_left != 4'd0) ? PH_GROUP : PH_FLAG;
                len_left <= {1'b0, ib} + LongLenBias;
                if ({19'd0, distance} > emitted) begin
                  status <= ST_BAD_REF;
                end else begin
                  state <= S_COPY_RD;
                end
              end
            endcase
          end
        end
        S_COPY_RD: begin
          if (len_left == 9'd0) begin
            state <= S_END;
          end else if (cap_hit) begin
            status <= ST_CAPACITY;
            state <= S_END;
          end else begin
            state <= S_COPY_WR;
          end
        end
        S_COPY_WR: begin
          if (lane_cnt != Lanes) begin
            lane <= lane | ({56'd0, rd_data} << {lane_cnt, 3'b000});
            lane_cnt <= lane_cnt + 4'd1;
            emitted <= emitted + 32'd1;
            len_left <= len_left - 9'd1;
            state <= S_COPY_RD;
          end else if (can_put) begin
            if (res_n < 6'(MaxResults)) begin
              out_data <= lane;
              out_count <= lane_cnt;
              out_done <= 1'b0;
              out_status <= ST_OK;
              res_n <= res_n + 6'd1;
            end
            lane <= {56'd0, rd_data};
            lane_cnt <= 4'd1;
            emitted <= emitted + 32'd1;
            len_left <= len_left - 9'd1;
            state <= S_COPY_RD;
          end
        end
        S_END: begin
          if (end_fin || lane_cnt != 4'd0) begin
            if (can_put) begin
              if (res_n < 6'(MaxResults)) begin
                out_data <= lane;
                out_count <= lane_cnt;
                out_done <= end_fin;
                out_status <= end_fin ? status : ST_OK;
                res_n <= res_n + 6'd1;
              end
              halted <= end_fin;
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

[rtl/core/lzwd_checker.sv]
`include "lz_window_byte_decompressor_unit_macros.svh"

module lzwd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_data,
  input logic [3:0]  out_count,
  input logic        out_done,
  input logic [1:0]  out_status
);
  import lzwd_pkg::*;

  `LZWD_ASSERT_NOW(a_count_range, out_valid, out_count <= 4'd8, "Item count above eight.")
  `LZWD_ASSERT_NOW(a_status_final, out_valid && out_status != ST_OK, out_done, "Status on a non-final item.")
  `LZWD_ASSERT_NOW(a_nonfinal_nonempty, out_valid && !out_done, out_count != 4'd0, "Empty non-final item.")
  `LZWD_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_data) && $stable(out_count), "Stalled item changed.")
endmodule

bind lz_window_byte_decompressor_unit lzwd_checker u_lzwd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .out_count (out_count),
  .out_done  (out_done),
  .out_status(out_status)
);
